### rtl/sgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sgc_pkg
// Types and constants shared by the scatter-gather cursor core.
// ============================================================================
package sgc_pkg;

    localparam int NUM_SEGMENTS_DEFAULT = 16;
    localparam int ADDRESS_BITS_DEFAULT = 32;

    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 4;
    localparam int WORD_W     = 32;
    localparam int S_TDATA_W  = 136;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 72;
    localparam int M_TUSER_W  = 3;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_PLACE   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_RETREAT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_NOT_POSITIONED = 2'd1,
        ST_END            = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_WALK  = 5'b00100,
        S_FETCH = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

endpackage
`default_nettype wire

### rtl/scatter_gather_cursor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// scatter_gather_cursor_core
// Segment table with a byte cursor that is placed, advanced and retreated.
// ============================================================================
// One command word is taken at a time and answered by one result word. A
// command passes through the states EXEC, FETCH and RESP before its result
// is written to the output register; RESP holds until that register is free.
// A step that crosses segments also stays in WALK between EXEC and FETCH
// while it reads each segment entered or skipped. The walk is paced by the
// segment table, a single memory with one read and one write port read one
// entry per cycle during the walk. The next command is accepted once the
// result is in the output register, even if it has not been taken yet.
// ============================================================================
module scatter_gather_cursor_core #(
    parameter int NUM_SEGMENTS = sgc_pkg::NUM_SEGMENTS_DEFAULT,
    parameter int ADDRESS_BITS = sgc_pkg::ADDRESS_BITS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           cfg_wr_en,
    input  wire logic [sgc_pkg::COUNT_W-1:0]    cfg_wr_data,   // segment_count

    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // segment_index[3:0], base_address[35:4], segment_length[67:36],
    // place_offset[99:68], step_count[131:100], zero pad
    input  wire logic [sgc_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  wire logic [sgc_pkg::S_TUSER_W-1:0]  s_tuser,

    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // byte_address[31:0], current_segment[35:32], offset_in_segment[67:36],
    // zero pad
    output logic [sgc_pkg::M_TDATA_W-1:0]       m_tdata,
    // status[1:0], position_valid[2]
    output logic [sgc_pkg::M_TUSER_W-1:0]       m_tuser
);

    localparam int IDX_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int UW_RAW = $clog2(NUM_SEGMENTS + 1);
    localparam int UW     = (UW_RAW > sgc_pkg::COUNT_W) ? UW_RAW : sgc_pkg::COUNT_W;
    localparam int OW     = (IDX_W > sgc_pkg::INDEX_W) ? IDX_W : sgc_pkg::INDEX_W;
    localparam int WW     = sgc_pkg::WORD_W;
    localparam logic [WW-1:0] ADDR_MASK = (ADDRESS_BITS >= WW) ? {WW{1'b1}} :
        WW'((64'd1 << ADDRESS_BITS) - 64'd1);
    localparam logic [UW-1:0] NUM_U = UW'(NUM_SEGMENTS);

    sgc_pkg::state_t  state_reg, state_next;
    sgc_pkg::cmd_t    cmd_reg;
    sgc_pkg::status_t status_reg, status_next;

    logic [sgc_pkg::INDEX_W-1:0] idx_reg;
    logic [WW-1:0]               base_in_reg;
    logic [WW-1:0]               len_in_reg;
    logic [WW-1:0]               place_reg;
    logic [WW-1:0]               steps_reg, steps_next;
    logic [sgc_pkg::COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]            cur_seg_reg, cur_seg_next;
    logic [WW-1:0]               cur_off_reg, cur_off_next;
    logic                        cur_valid_reg, cur_valid_next;
    logic [UW-1:0]               walk_reg, walk_next;

    logic                        m_valid_reg;
    logic [sgc_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [sgc_pkg::M_TUSER_W-1:0] m_tuser_reg;

    logic [2*WW-1:0] seg_mem [NUM_SEGMENTS];
    logic [2*WW-1:0] rd_data_reg;
    logic            wr_en;
    logic [UW-1:0]   rd_sel;
    logic [IDX_W-1:0] rd_addr;

    logic [UW-1:0]   used;
    logic [UW-1:0]   cfg_used;
    logic [UW-1:0]   idx_u;
    logic [UW-1:0]   cur_u;
    logic [UW-1:0]   walk_inc;
    logic [WW-1:0]   rd_len;
    logic [WW-1:0]   rd_base;
    logic [WW-1:0]   room;
    logic [WW-1:0]   out_addr;
    logic [OW-1:0]   cur_seg_ext;
    logic            accept;
    logic            out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == sgc_pkg::S_IDLE);

    assign used     = (UW'(count_reg) > NUM_U) ? NUM_U : UW'(count_reg);
    assign cfg_used = (UW'(cfg_wr_data) > NUM_U) ? NUM_U : UW'(cfg_wr_data);
    assign idx_u    = UW'(idx_reg);
    assign cur_u    = UW'(cur_seg_reg);
    assign walk_inc = walk_reg + UW'(1);
    assign rd_len   = rd_data_reg[WW-1:0];
    assign rd_base  = rd_data_reg[2*WW-1:WW];
    assign room     = rd_len - cur_off_reg;
    assign rd_addr  = rd_sel[IDX_W-1:0];
    assign out_addr = (rd_base + cur_off_reg) & ADDR_MASK;
    assign cur_seg_ext = OW'(cur_seg_reg);

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        steps_next     = steps_reg;
        cur_seg_next   = cur_seg_reg;
        cur_off_next   = cur_off_reg;
        cur_valid_next = cur_valid_reg;
        walk_next      = walk_reg;
        wr_en          = 1'b0;
        rd_sel         = cur_u;

        unique case (state_reg)
            sgc_pkg::S_IDLE: begin
                if (cfg_wr_en && cur_valid_reg && (cur_u >= cfg_used)) begin
                    cur_valid_next = 1'b0;
                    cur_seg_next   = '0;
                    cur_off_next   = '0;
                end
                if (accept) begin
                    steps_next = s_tdata[131:100];
                    if (sgc_pkg::cmd_t'(s_tuser[1:0]) == sgc_pkg::CMD_PLACE) begin
                        rd_sel = UW'(s_tdata[3:0]);
                    end
                    state_next = sgc_pkg::S_EXEC;
                end
            end

            sgc_pkg::S_EXEC: begin
                status_next = sgc_pkg::ST_OK;
                state_next  = sgc_pkg::S_FETCH;
                unique case (cmd_reg)
                    sgc_pkg::CMD_WRITE: begin
                        if (idx_u < NUM_U) begin
                            wr_en = 1'b1;
                            if (cur_valid_reg && (cur_u == idx_u)) begin
                                cur_valid_next = 1'b0;
                                cur_seg_next   = '0;
                                cur_off_next   = '0;
                            end
                        end
                    end
                    sgc_pkg::CMD_PLACE: begin
                        if ((idx_u < used) && (place_reg < rd_len)) begin
                            cur_seg_next   = idx_u[IDX_W-1:0];
                            cur_off_next   = place_reg;
                            cur_valid_next = 1'b1;
                        end else begin
                            cur_valid_next = 1'b0;
                            cur_seg_next   = '0;
                            cur_off_next   = '0;
                            status_next    = sgc_pkg::ST_NOT_POSITIONED;
                        end
                    end
                    sgc_pkg::CMD_ADVANCE, sgc_pkg::CMD_RETREAT: begin
                        priority if (!cur_valid_reg) begin
                            status_next = sgc_pkg::ST_NOT_POSITIONED;
                        end else if (steps_reg == '0) begin
                            status_next = sgc_pkg::ST_OK;
                        end else if (cmd_reg == sgc_pkg::CMD_ADVANCE) begin
                            if (steps_reg < room) begin
                                cur_off_next = cur_off_reg + steps_reg;
                            end else begin
                                steps_next = steps_reg - room;
                                walk_next  = cur_u + UW'(1);
                                if ((cur_u + UW'(1)) >= used) begin
                                    cur_valid_next = 1'b0;
                                    cur_seg_next   = '0;
                                    cur_off_next   = '0;
                                    status_next    = sgc_pkg::ST_END;
                                end else begin
                                    rd_sel     = cur_u + UW'(1);
                                    state_next = sgc_pkg::S_WALK;
                                end
                            end
                        end else begin
                            if (steps_reg <= cur_off_reg) begin
                                cur_off_next = cur_off_reg - steps_reg;
                            end else begin
                                steps_next = steps_reg - cur_off_reg - WW'(1);
                                walk_next  = cur_u - UW'(1);
                                if (cur_u == '0) begin
                                    cur_valid_next = 1'b0;
                                    cur_seg_next   = '0;
                                    cur_off_next   = '0;
                                    status_next    = sgc_pkg::ST_END;
                                end else begin
                                    rd_sel     = cur_u - UW'(1);
                                    state_next = sgc_pkg::S_WALK;
                                end
                            end
                        end
                    end
                    default: begin
                        state_next = sgc_pkg::S_FETCH;
                    end
                endcase
            end

            sgc_pkg::S_WALK: begin
                if (steps_reg < rd_len) begin
                    cur_seg_next = walk_reg[IDX_W-1:0];
                    cur_off_next = (cmd_reg == sgc_pkg::CMD_RETREAT) ?
                                   (rd_len - WW'(1) - steps_reg) : steps_reg;
                    rd_sel       = walk_reg;
                    state_next   = sgc_pkg::S_FETCH;
                end else begin
                    steps_next = steps_reg - rd_len;
                    if (cmd_reg == sgc_pkg::CMD_RETREAT) begin
                        if (walk_reg == '0) begin
                            cur_valid_next = 1'b0;
                            cur_seg_next   = '0;
                            cur_off_next   = '0;
                            status_next    = sgc_pkg::ST_END;
                            state_next     = sgc_pkg::S_FETCH;
                        end else begin
                            walk_next = walk_reg - UW'(1);
                            rd_sel    = walk_reg - UW'(1);
                        end
                    end else begin
                        if (walk_inc >= used) begin
                            cur_valid_next = 1'b0;
                            cur_seg_next   = '0;
                            cur_off_next   = '0;
                            status_next    = sgc_pkg::ST_END;
                            state_next     = sgc_pkg::S_FETCH;
                        end else begin
                            walk_next = walk_inc;
                            rd_sel    = walk_inc;
                        end
                    end
                end
            end

            sgc_pkg::S_FETCH: begin
                state_next = sgc_pkg::S_RESP;
            end

            sgc_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = sgc_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = sgc_pkg::S_IDLE;
            end
        endcase
    end

    // segment table: {base, length} per entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            seg_mem[idx_u[IDX_W-1:0]] <= {base_in_reg, len_in_reg};
        end
        rd_data_reg <= seg_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= sgc_pkg::cmd_t'(s_tuser[1:0]);
            idx_reg     <= s_tdata[3:0];
            base_in_reg <= s_tdata[35:4];
            len_in_reg  <= s_tdata[67:36];
            place_reg   <= s_tdata[99:68];
        end
        steps_reg <= steps_next;
        walk_reg  <= walk_next;
        if ((state_reg == sgc_pkg::S_RESP) && out_free) begin
            m_tuser_reg <= {cur_valid_reg, status_reg};
            if (cur_valid_reg) begin
                m_tdata_reg <= {4'd0, cur_off_reg, cur_seg_ext[3:0], out_addr};
            end else begin
                m_tdata_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sgc_pkg::S_IDLE;
            status_reg    <= sgc_pkg::ST_OK;
            count_reg     <= '0;
            cur_seg_reg   <= '0;
            cur_off_reg   <= '0;
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            cur_seg_reg   <= cur_seg_next;
            cur_off_reg   <= cur_off_next;
            cur_valid_reg <= cur_valid_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
            if ((state_reg == sgc_pkg::S_RESP) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (cur_u < used))
        else $error("cursor outside segments in use");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sgc_pkg::S_WALK) |-> (walk_reg < used))
        else $error("walk index outside segments in use");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == sgc_pkg::S_EXEC))
        else $error("accepted word not executed");

    a_end_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[1:0] == sgc_pkg::ST_END)) |-> !m_tuser[2])
        else $error("end of list with valid position");

endmodule
`default_nettype wire
